// ===== sv/ordered_list_engine_core_macros.svh =====
// assertion macros for the ordered list engine checker
`ifndef ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define OLST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define OLST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/olst_pkg.sv =====
// shared types and constants of the ordered list engine
package olst_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int POS_IN_W     = 8;
    localparam int OCC_W        = 7;
    localparam int LEN_W        = 7;
    localparam int POS_OUT_W    = 6;
    localparam int MATCH_W      = 7;

    // request codes
    typedef enum logic [2:0] {
        OP_INSERT      = 3'd0,
        OP_ERASE       = 3'd1,
        OP_ERASE_FIRST = 3'd2,
        OP_ERASE_LAST  = 3'd3,
        OP_ERASE_NTH   = 3'd4,
        OP_COUNT       = 3'd5,
        OP_READ        = 3'd6
    } t_op;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_BAD_INDEX      = 3'd1,
        ST_NOT_FOUND      = 3'd2,
        ST_FULL           = 3'd3,
        ST_BAD_OCCURRENCE = 3'd4
    } t_status;

    // control from the sequencer to the match unit
    typedef struct packed {
        logic clr;
        logic vld;
        t_op  op;
    } t_scan_ctl;

    // match unit results
    typedef struct packed {
        logic               found;
        logic [MATCH_W-1:0] match_cnt;
    } t_scan_res;

endpackage

// ===== sv/olst_mem.sv =====
// entry store: one write port, one registered read port
module olst_mem import olst_pkg::*; #(
    parameter  int DEPTH = CAPACITY_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered; data held while i_re is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== sv/olst_scan.sv =====
// match unit: compares streamed entries with the key and tracks hits
module olst_scan import olst_pkg::*; #(
    parameter  int DEPTH = CAPACITY_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_scan_ctl         i_ctl,
    input  logic [AW-1:0]     i_idx,
    input  logic [DATA_W-1:0] i_rdata,
    input  logic [DATA_W-1:0] i_value,
    input  logic [OCC_W-1:0]  i_occ,
    output t_scan_res         o_res,
    output logic [AW-1:0]     o_hit
);

    logic               r_found;
    logic [MATCH_W-1:0] r_matches;
    logic [AW-1:0]      r_hit;
    logic               n_found;
    logic [MATCH_W-1:0] n_matches;
    logic [AW-1:0]      n_hit;
    logic               s_eq;
    logic [MATCH_W-1:0] s_inc;

    assign s_eq  = i_ctl.vld && (i_rdata == i_value);
    // saturating match counter
    assign s_inc = (r_matches == '1) ? r_matches : r_matches + MATCH_W'(1);

    // hit selection per search kind
    always_comb begin
        n_found   = r_found;
        n_matches = r_matches;
        n_hit     = r_hit;
        if (i_ctl.clr) begin
            n_found   = 1'b0;
            n_matches = '0;
        end else if (s_eq) begin
            n_matches = s_inc;
            unique case (i_ctl.op)
                OP_ERASE_FIRST: begin
                    if (!r_found) begin
                        n_found = 1'b1;
                        n_hit   = i_idx;
                    end
                end
                OP_ERASE_LAST: begin
                    n_found = 1'b1;
                    n_hit   = i_idx;
                end
                OP_ERASE_NTH: begin
                    if (!r_found && (s_inc == i_occ)) begin
                        n_found = 1'b1;
                        n_hit   = i_idx;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found   <= 1'b0;
            r_matches <= '0;
        end else begin
            r_found   <= n_found;
            r_matches <= n_matches;
        end
    end

    // hit index
    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
    end

    assign o_res.found     = r_found;
    assign o_res.match_cnt = r_matches;
    assign o_hit           = r_hit;

endmodule

// ===== sv/ordered_list_engine_core.sv =====
// ordered list engine top level: request sequencer, entry store and match unit
//
// usage
//   a request transaction is taken at a rising edge with start high and busy low.
//   fields: i_operation, i_position_in, i_value_in, i_occurrence.
//   each request gives exactly one result, shown for one cycle with o_done high;
//   the receiver cannot stall, so o_done is a strobe and must be sampled then.
//   o_length shows the entry count after the request.
// steps of a request (n = entries held)
//   rejected requests and code 7: result in the cycle after the request, not busy.
//   read: one store read, then the result. append: no shift. insert at p below n:
//   entries p to n-1 move up one place from the tail down, then the new value is
//   written. erase at p: the entries after p move down one place. count: a search
//   over all entries. erase first/last/nth: a search over all entries, then the
//   entries after the hit move down one place. the single read port of the entry
//   store sets the pace: the search streams one entry a cycle, and the shift moves
//   one entry a cycle.
// reset
//   synchronous, active low; the list is empty after reset, no clearing pass.
module ordered_list_engine_core import olst_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_operation,
    input  logic [POS_IN_W-1:0]  i_position_in,
    input  logic [DATA_W-1:0]    i_value_in,
    input  logic [OCC_W-1:0]     i_occurrence,
    output logic                 o_done,
    output logic [2:0]           o_status,
    output logic [LEN_W-1:0]     o_length,
    output logic [POS_OUT_W-1:0] o_position_out,
    output logic [DATA_W-1:0]    o_read_value,
    output logic [MATCH_W-1:0]   o_match_count
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_IN_W) ? CW : POS_IN_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MOVE = 4'b0100,
        S_READ = 4'b1000
    } t_state;

    // control registers
    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_left, n_left;
    logic                  r_wv, n_wv;
    logic                  r_sv, n_sv;
    logic                  r_done, n_done;
    // payload registers
    t_op                   r_op, n_op;
    logic [DATA_W-1:0]     r_val, n_val;
    logic [OCC_W-1:0]      r_occ, n_occ;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_src, n_src;
    logic [AW-1:0]         r_wa, n_wa;
    logic [AW-1:0]         r_si, n_si;
    logic                  r_up, n_up;
    t_status               r_status, n_status;
    logic [POS_OUT_W-1:0]  r_pos_out, n_pos_out;
    logic [DATA_W-1:0]     r_rd, n_rd;
    logic [MATCH_W-1:0]    r_match, n_match;

    // store and match unit hookup
    logic                  s_re;
    logic [AW-1:0]         s_raddr;
    logic [DATA_W-1:0]     s_rdata;
    logic                  s_we;
    logic [AW-1:0]         s_waddr;
    logic [DATA_W-1:0]     s_wdata;
    t_scan_ctl             s_scan_ctl;
    t_scan_res             s_scan_res;
    logic [AW-1:0]         s_hit;
    logic [CMPW-1:0]       s_pos_ext;
    logic [CMPW-1:0]       s_cnt_ext;
    t_op                   s_req_op;

    assign s_pos_ext = CMPW'(i_position_in);
    assign s_cnt_ext = CMPW'(r_count);
    assign s_req_op  = t_op'(i_operation);

    olst_mem #(.DEPTH(CAPACITY)) u_mem (
        .i_clk   (i_clk),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata)
    );

    olst_scan #(.DEPTH(CAPACITY)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_scan_ctl),
        .i_idx   (r_si),
        .i_rdata (s_rdata),
        .i_value (r_val),
        .i_occ   (r_occ),
        .o_res   (s_scan_res),
        .o_hit   (s_hit)
    );

    // request sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_wv      = 1'b0;
        n_sv      = 1'b0;
        n_done    = 1'b0;
        n_op      = r_op;
        n_val     = r_val;
        n_occ     = r_occ;
        n_idx     = r_idx;
        n_src     = r_src;
        n_wa      = r_wa;
        n_si      = r_si;
        n_up      = r_up;
        n_status  = r_status;
        n_pos_out = r_pos_out;
        n_rd      = r_rd;
        n_match   = r_match;

        s_re           = 1'b0;
        s_raddr        = '0;
        s_scan_ctl.clr = 1'b0;
        s_scan_ctl.vld = r_sv;
        s_scan_ctl.op  = r_op;

        // pending shift write: data read last cycle goes to its new place
        s_we    = r_wv;
        s_waddr = r_wa;
        s_wdata = s_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op      = s_req_op;
                    n_val     = i_value_in;
                    n_occ     = i_occurrence;
                    n_status  = ST_OK;
                    n_pos_out = '0;
                    n_rd      = '0;
                    n_match   = '0;
                    unique case (s_req_op)
                        OP_INSERT: begin
                            if (s_pos_ext > s_cnt_ext) begin
                                n_status = ST_BAD_INDEX;
                                n_done   = 1'b1;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_done   = 1'b1;
                            end else begin
                                n_idx   = AW'(i_position_in);
                                n_left  = r_count - CW'(i_position_in);
                                n_src   = AW'(r_count - CW'(1));
                                n_up    = 1'b1;
                                n_state = S_MOVE;
                            end
                        end
                        OP_ERASE: begin
                            if (s_pos_ext >= s_cnt_ext) begin
                                n_status = ST_BAD_INDEX;
                                n_done   = 1'b1;
                            end else begin
                                n_idx   = AW'(i_position_in);
                                n_left  = r_count - CW'(i_position_in) - CW'(1);
                                n_src   = AW'(CW'(i_position_in) + CW'(1));
                                n_up    = 1'b0;
                                n_state = S_MOVE;
                            end
                        end
                        OP_ERASE_FIRST, OP_ERASE_LAST, OP_COUNT: begin
                            s_scan_ctl.clr = 1'b1;
                            n_src          = '0;
                            n_left         = r_count;
                            n_state        = S_SCAN;
                        end
                        OP_ERASE_NTH: begin
                            if (i_occurrence == '0) begin
                                n_status = ST_BAD_OCCURRENCE;
                                n_done   = 1'b1;
                            end else begin
                                s_scan_ctl.clr = 1'b1;
                                n_src          = '0;
                                n_left         = r_count;
                                n_state        = S_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (s_pos_ext >= s_cnt_ext) begin
                                n_status = ST_BAD_INDEX;
                                n_done   = 1'b1;
                            end else begin
                                s_re    = 1'b1;
                                s_raddr = AW'(i_position_in);
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_left != '0) begin
                    // stream the next entry into the match unit
                    s_re    = 1'b1;
                    s_raddr = r_src;
                    n_sv    = 1'b1;
                    n_si    = r_src;
                    n_src   = r_src + AW'(1);
                    n_left  = r_left - CW'(1);
                end else if (!r_sv) begin
                    // last compare is in, results are final
                    if (r_op == OP_COUNT) begin
                        n_match = s_scan_res.match_cnt;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else if (s_scan_res.found) begin
                        n_idx   = s_hit;
                        n_left  = r_count - CW'(1) - CW'(s_hit);
                        n_src   = s_hit + AW'(1);
                        n_up    = 1'b0;
                        n_state = S_MOVE;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_MOVE: begin
                if (r_left != '0) begin
                    // read one entry, write it one place up or down next cycle
                    s_re    = 1'b1;
                    s_raddr = r_src;
                    n_wv    = 1'b1;
                    n_wa    = r_up ? r_src + AW'(1) : r_src - AW'(1);
                    n_src   = r_up ? r_src - AW'(1) : r_src + AW'(1);
                    n_left  = r_left - CW'(1);
                end else if (!r_wv) begin
                    // shift drained: place the new value or drop the tail
                    if (r_up) begin
                        s_we    = 1'b1;
                        s_waddr = r_idx;
                        s_wdata = r_val;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                    n_pos_out = POS_OUT_W'(r_idx);
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_READ: begin
                n_rd    = s_rdata;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
            r_wv    <= 1'b0;
            r_sv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_wv    <= n_wv;
            r_sv    <= n_sv;
            r_done  <= n_done;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_val     <= n_val;
        r_occ     <= n_occ;
        r_idx     <= n_idx;
        r_src     <= n_src;
        r_wa      <= n_wa;
        r_si      <= n_si;
        r_up      <= n_up;
        r_status  <= n_status;
        r_pos_out <= n_pos_out;
        r_rd      <= n_rd;
        r_match   <= n_match;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_length       = LEN_W'(r_count);
    assign o_position_out = r_pos_out;
    assign o_read_value   = r_rd;
    assign o_match_count  = r_match;

endmodule

// ===== sv/olst_chk.sv =====
// port-level checker for the ordered list engine, bound to the top level
`include "ordered_list_engine_core_macros.svh"

module olst_chk import olst_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input logic [2:0]           o_status,
    input logic [LEN_W-1:0]     o_length,
    input logic [POS_OUT_W-1:0] o_position_out,
    input logic [DATA_W-1:0]    o_read_value,
    input logic [MATCH_W-1:0]   o_match_count
);

    // an accepted transaction either answers at once or keeps the block busy
    `OLST_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_done,
        "accepted transaction neither answered nor in progress")

    // a failed request reports no position and no data
    `OLST_ASSERT_NOW(a_fail_clean, o_done && (o_status != ST_OK),
        (o_position_out == '0) && (o_read_value == '0) && (o_match_count == '0),
        "failed request carries result data")

    // full is only reported when the list holds capacity entries
    `OLST_ASSERT_NOW(a_full_length, o_done && (o_status == ST_FULL),
        o_length == LEN_W'(CAPACITY),
        "full status with list below capacity")

    // a nonzero match count only comes from a successful count
    `OLST_ASSERT_NOW(a_count_only, o_done && (o_match_count != '0),
        (o_status == ST_OK) && (o_position_out == '0) && (o_read_value == '0),
        "match count reported together with other result data")

endmodule

bind ordered_list_engine_core olst_chk #(.CAPACITY(CAPACITY)) u_olst_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_length       (o_length),
    .o_position_out (o_position_out),
    .o_read_value   (o_read_value),
    .o_match_count  (o_match_count)
);

// ===== tb/tb_ordered_list_engine_core.sv =====
// self-checking testbench of the ordered list engine core
module tb_ordered_list_engine_core import olst_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int N_RANDOM    = 1700;
    localparam int POOL_SIZE   = 6;
    // code 7 is not a defined request
    localparam logic [2:0] OP_UNDEFINED = 3'd7;

    // expected content of one result transaction
    typedef struct packed {
        t_status              status;
        logic [LEN_W-1:0]     length;
        logic [POS_OUT_W-1:0] position;
        logic [DATA_W-1:0]    read_value;
        logic [MATCH_W-1:0]   match_count;
    } list_outcome_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [2:0]           i_operation;
    logic [POS_IN_W-1:0]  i_position_in;
    logic [DATA_W-1:0]    i_value_in;
    logic [OCC_W-1:0]     i_occurrence;
    logic                 o_done;
    logic [2:0]           o_status;
    logic [LEN_W-1:0]     o_length;
    logic [POS_OUT_W-1:0] o_position_out;
    logic [DATA_W-1:0]    o_read_value;
    logic [MATCH_W-1:0]   o_match_count;

    // shadow copy of the list
    logic [DATA_W-1:0] shadow_entries [CAPACITY];
    int                shadow_len;
    int                peak_len;

    list_outcome_t pending_outcomes [$];
    logic [DATA_W-1:0] value_pool [POOL_SIZE];

    int  mismatch_count;
    int  result_count;
    int  cycle_count;
    int  op_seen [8];
    int  status_seen [8];
    bit  idle_enabled;

    ordered_list_engine_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_position_in  (i_position_in),
        .i_value_in     (i_value_in),
        .i_occurrence   (i_occurrence),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_length       (o_length),
        .o_position_out (o_position_out),
        .o_read_value   (o_read_value),
        .o_match_count  (o_match_count)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // drop the entry at idx from the shadow list
    function automatic void remove_shadow_entry(int idx);
        for (int k = idx; k + 1 < shadow_len; k++)
            shadow_entries[k] = shadow_entries[k + 1];
        shadow_len--;
    endfunction

    // apply one request to the shadow list and return its result
    function automatic list_outcome_t compute_list_outcome(logic [2:0] op,
                                                           logic [POS_IN_W-1:0] pos,
                                                           logic [DATA_W-1:0] val,
                                                           logic [OCC_W-1:0] occ);
        list_outcome_t res;
        int            hit;
        int            seen;
        bit            found;
        res    = '0;
        res.status = ST_OK;
        hit    = 0;
        seen   = 0;
        found  = 1'b0;
        case (op)
            OP_INSERT: begin
                if (int'(pos) > shadow_len) begin
                    res.status = ST_BAD_INDEX;
                end else if (shadow_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int k = shadow_len; k > int'(pos); k--)
                        shadow_entries[k] = shadow_entries[k - 1];
                    shadow_entries[pos] = val;
                    shadow_len++;
                    res.position = pos[POS_OUT_W-1:0];
                end
            end
            OP_ERASE: begin
                if (int'(pos) >= shadow_len) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    remove_shadow_entry(pos);
                    res.position = pos[POS_OUT_W-1:0];
                end
            end
            OP_ERASE_FIRST, OP_ERASE_LAST: begin
                for (int k = 0; k < shadow_len; k++) begin
                    if (shadow_entries[k] == val) begin
                        if (!found || op == OP_ERASE_LAST)
                            hit = k;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    remove_shadow_entry(hit);
                    res.position = hit[POS_OUT_W-1:0];
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            OP_ERASE_NTH: begin
                if (occ == '0) begin
                    res.status = ST_BAD_OCCURRENCE;
                end else begin
                    for (int k = 0; k < shadow_len && !found; k++) begin
                        if (shadow_entries[k] == val) begin
                            seen++;
                            if (seen == int'(occ)) begin
                                found = 1'b1;
                                hit   = k;
                            end
                        end
                    end
                    if (found) begin
                        remove_shadow_entry(hit);
                        res.position = hit[POS_OUT_W-1:0];
                    end else begin
                        res.status = ST_NOT_FOUND;
                    end
                end
            end
            OP_COUNT: begin
                for (int k = 0; k < shadow_len; k++)
                    if (shadow_entries[k] == val)
                        seen++;
                if (seen > 127)
                    seen = 127;
                res.match_count = seen[MATCH_W-1:0];
            end
            OP_READ: begin
                if (int'(pos) >= shadow_len)
                    res.status = ST_BAD_INDEX;
                else
                    res.read_value = shadow_entries[pos];
            end
            default: begin
            end
        endcase
        res.length = shadow_len[LEN_W-1:0];
        if (shadow_len > peak_len)
            peak_len = shadow_len;
        return res;
    endfunction

    // idle length before the next request
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!idle_enabled || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // search values: mostly from a small pool so that matches are common
    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(99) < 85)
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic void refresh_pool();
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hffff_ffff;
        value_pool[2] = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        for (int k = 3; k < POOL_SIZE; k++)
            value_pool[k] = $urandom;
    endfunction

    // drive one request transaction and record its expected result once taken
    task automatic send_request(logic [2:0] op, logic [POS_IN_W-1:0] pos,
                                logic [DATA_W-1:0] val, logic [OCC_W-1:0] occ);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_operation   <= op;
        i_position_in <= pos;
        i_value_in    <= val;
        i_occurrence  <= occ;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_outcomes.push_back(compute_list_outcome(op, pos, val, occ));
        op_seen[op]++;
    endtask

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        list_outcome_t want;
        if (i_rst_n && o_done) begin
            result_count++;
            if (pending_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result at cycle %0d: status %0d length %0d",
                             cycle_count, o_status, o_length);
            end else begin
                want = pending_outcomes.pop_front();
                status_seen[want.status]++;
                if (o_status !== want.status || o_length !== want.length ||
                    o_position_out !== want.position ||
                    o_read_value !== want.read_value ||
                    o_match_count !== want.match_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at cycle %0d (result %0d)", cycle_count,
                                 result_count);
                        $display("  expected status %0d length %0d pos %0d read %h count %0d",
                                 want.status, want.length, want.position,
                                 want.read_value, want.match_count);
                        $display("  actual   status %0d length %0d pos %0d read %h count %0d",
                                 o_status, o_length, o_position_out, o_read_value,
                                 o_match_count);
                    end
                end
            end
        end
    end

    // extremes, every request type and each reject but full on a short list
    task automatic test_directed_cases();
        idle_enabled = 1'b1;
        // requests on the empty list, most of them rejected
        send_request(OP_READ, 8'd0, 32'h0, 7'd0);
        send_request(OP_ERASE, 8'd0, 32'h0, 7'd0);
        send_request(OP_ERASE_FIRST, 8'd0, 32'h0, 7'd0);
        send_request(OP_ERASE_LAST, 8'd0, 32'hffff_ffff, 7'd0);
        send_request(OP_ERASE_NTH, 8'd0, 32'h0, 7'd0);
        send_request(OP_ERASE_NTH, 8'd0, 32'h0, 7'd1);
        send_request(OP_COUNT, 8'd0, 32'h0, 7'd0);
        send_request(OP_UNDEFINED, 8'hff, 32'hffff_ffff, 7'h7f);
        send_request(OP_INSERT, 8'd1, 32'h1, 7'd0);
        send_request(OP_INSERT, 8'hff, 32'h1, 7'd0);
        // front, append and middle inserts with extreme values
        send_request(OP_INSERT, 8'd0, 32'h8000_0000, 7'd0);
        send_request(OP_INSERT, 8'd1, 32'h7fff_ffff, 7'd0);
        send_request(OP_INSERT, 8'd0, 32'h7fff_ffff, 7'd0);
        send_request(OP_INSERT, 8'd1, 32'hffff_ffff, 7'd0);
        send_request(OP_COUNT, 8'd0, 32'h7fff_ffff, 7'd0);
        send_request(OP_ERASE_NTH, 8'd0, 32'h7fff_ffff, 7'h7f);
        send_request(OP_ERASE_NTH, 8'd0, 32'h7fff_ffff, 7'd2);
        send_request(OP_READ, 8'hff, 32'h0, 7'd0);
        send_request(OP_READ, 8'd2, 32'h0, 7'd0);
        send_request(OP_UNDEFINED, 8'd0, 32'h0, 7'd0);
        send_request(OP_ERASE, 8'hff, 32'h0, 7'd0);
        send_request(OP_ERASE_LAST, 8'd0, 32'h8000_0000, 7'd0);
        send_request(OP_ERASE_FIRST, 8'd0, 32'hffff_ffff, 7'd0);
        send_request(OP_ERASE, 8'd0, 32'h0, 7'd0);
    endtask

    // fill to capacity, probe the full list, then drain it
    task automatic test_full_list();
        idle_enabled = 1'b0;
        refresh_pool();
        while (shadow_len < CAPACITY)
            send_request(OP_INSERT, 8'($urandom_range(shadow_len)), pick_value(), 7'd0);
        idle_enabled = 1'b1;
        send_request(OP_INSERT, 8'(CAPACITY), 32'h5a5a_5a5a, 7'd0);
        send_request(OP_INSERT, 8'(CAPACITY + 1), 32'h5a5a_5a5a, 7'd0);
        send_request(OP_INSERT, 8'd0, 32'h5a5a_5a5a, 7'd0);
        send_request(OP_READ, 8'(CAPACITY - 1), 32'h0, 7'd0);
        send_request(OP_READ, 8'(CAPACITY), 32'h0, 7'd0);
        send_request(OP_COUNT, 8'd0, value_pool[0], 7'd0);
        send_request(OP_ERASE_NTH, 8'd0, value_pool[1], 7'd3);
        send_request(OP_ERASE, 8'(CAPACITY - 1), 32'h0, 7'd0);
        send_request(OP_INSERT, 8'(shadow_len), 32'h8000_0000, 7'd0);
        while (shadow_len > 0) begin
            if ($urandom_range(9) < 7)
                send_request(OP_ERASE, 8'($urandom_range(shadow_len - 1)), 32'h0, 7'd0);
            else
                send_request(($urandom_range(1) != 0) ? OP_ERASE_FIRST : OP_ERASE_LAST,
                             8'd0, pick_value(), 7'd0);
        end
    endtask

    // long mix of requests around a drifting target length
    task automatic test_random_mix();
        int               target;
        int               r;
        bit               grow;
        logic [2:0]       op;
        logic [POS_IN_W-1:0] pos;
        logic [OCC_W-1:0] occ;
        for (int n = 0; n < N_RANDOM; n++) begin
            // new phase: target length, value pool and idling
            if (n % 100 == 0) begin
                r = $urandom_range(9);
                target = (r == 0) ? 0 : (r == 1) ? CAPACITY : $urandom_range(CAPACITY);
                refresh_pool();
                idle_enabled = ($urandom_range(3) != 0);
            end
            grow = (shadow_len < target);
            r    = $urandom_range(99);
            occ  = 7'($urandom_range(4, 1));
            pos  = (shadow_len > 0) ? 8'($urandom_range(shadow_len - 1)) : 8'd0;
            if (r < 6) begin
                // noise over the whole field ranges
                op  = 3'($urandom_range(7));
                pos = 8'($urandom_range(255));
                occ = 7'($urandom_range(127));
                send_request(op, pos, $urandom, occ);
            end else if (r < (grow ? 55 : 20)) begin
                pos = ($urandom_range(9) == 0) ? 8'(shadow_len) :
                      8'($urandom_range(shadow_len));
                send_request(OP_INSERT, pos, pick_value(), occ);
            end else if (r < (grow ? 62 : 45)) begin
                if ($urandom_range(9) == 0)
                    pos = 8'(shadow_len);
                send_request(OP_ERASE, pos, pick_value(), occ);
            end else if (r < (grow ? 70 : 60)) begin
                send_request(OP_ERASE_FIRST, pos, pick_value(), occ);
            end else if (r < 76) begin
                send_request(OP_ERASE_LAST, pos, pick_value(), occ);
            end else if (r < 84) begin
                if ($urandom_range(9) == 0)
                    occ = 7'($urandom_range(127));
                send_request(OP_ERASE_NTH, pos, pick_value(), occ);
            end else if (r < 92) begin
                send_request(OP_COUNT, pos, pick_value(), occ);
            end else begin
                if ($urandom_range(9) == 0)
                    pos = 8'($urandom_range(255));
                send_request(OP_READ, pos, pick_value(), occ);
            end
        end
    endtask

    // stop driving and let every outstanding result arrive
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (2 * CAPACITY + 8) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = '0;
        i_position_in  = '0;
        i_value_in     = '0;
        i_occurrence   = '0;
        shadow_len     = 0;
        peak_len       = 0;
        mismatch_count = 0;
        result_count   = 0;
        cycle_count    = 0;
        idle_enabled   = 1'b1;
        foreach (op_seen[k]) op_seen[k] = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
        foreach (shadow_entries[k]) shadow_entries[k] = '0;
        refresh_pool();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_full_list();
        test_random_mix();
        drain_results();

        $display("covered %0d results: insert %0d erase %0d first %0d last %0d nth %0d",
                 result_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
        $display("  count %0d read %0d undefined %0d, peak length %0d, statuses %0d/%0d/%0d/%0d/%0d",
                 op_seen[5], op_seen[6], op_seen[7], peak_len, status_seen[0],
                 status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/olst_pkg.sv
sv/olst_mem.sv
sv/olst_scan.sv
sv/ordered_list_engine_core.sv
sv/olst_chk.sv
tb/tb_ordered_list_engine_core.sv
